>>> hdl/assert_macros.svh
// Assertion macros shared by the RTL of the frame deframer.
// Included by files that carry concurrent assertions; depends on nothing.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");

// Next-cycle implication, checked outside reset.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`endif

>>> hdl/slfd_pkg.sv
// Package of the sync/length frame deframer: result type, kind codes and
// frame constants. Depends on nothing.
`default_nettype none

package slfd_pkg;

  // Result kinds.
  localparam logic [2:0] KIND_PAYLOAD    = 3'd0;
  localparam logic [2:0] KIND_FORWARD    = 3'd1;
  localparam logic [2:0] KIND_BLE_LISTEN = 3'd2;
  localparam logic [2:0] KIND_BLE_TIMED  = 3'd3;
  localparam logic [2:0] KIND_FAST_MODE  = 3'd4;

  // Frame delimiters and command bytes.
  localparam logic [7:0] SYNC_FIRST   = 8'd29;
  localparam logic [7:0] SYNC_SECOND  = 8'd115;
  localparam logic [7:0] CMD_HIGH     = 8'd177;
  localparam logic [7:0] CMD_LOW      = 8'd103;
  localparam logic [7:0] CMD_LISTEN   = 8'd39;
  localparam logic [7:0] CMD_TIMED_LO = 8'd40;
  localparam logic [7:0] CMD_TIMED_HI = 8'd42;

  localparam logic [5:0] BLE_CH_FIRST = 6'd37;

  localparam logic [15:0] LENGTH_LIMIT_RESET = 16'd256;

  // Register index of the length limit.
  localparam logic REG_LENGTH_LIMIT = 1'b0;

  typedef struct packed {
    logic [2:0] kind;
    logic [7:0] data_byte;
    logic [7:0] byte_index;
    logic [7:0] frame_length;
    logic [8:0] reply_length;
    logic       ble_listen;
    logic       timestamped;
    logic [5:0] ble_channel;
  } result_t;

endpackage

`default_nettype wire

>>> hdl/slfd_rx_if.sv
// Receive byte channel: valid/ready handshake carrying one serial byte.
// Depends on nothing.
`default_nettype none

interface slfd_rx_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

`default_nettype wire

>>> hdl/slfd_res_if.sv
// Result channel: valid/ready handshake carrying one parsed result.
// Depends on nothing.
`default_nettype none

interface slfd_res_if;
  logic       valid;
  logic       ready;
  logic [2:0] kind;
  logic [7:0] data_byte;
  logic [7:0] byte_index;
  logic [7:0] frame_length;
  logic [8:0] reply_length;
  logic       ble_listen;
  logic       timestamped;
  logic [5:0] ble_channel;

  modport source (output valid, output kind, output data_byte, output byte_index,
                  output frame_length, output reply_length, output ble_listen,
                  output timestamped, output ble_channel, input ready);
  modport sink (input valid, input kind, input data_byte, input byte_index,
                input frame_length, input reply_length, input ble_listen,
                input timestamped, input ble_channel, output ready);
endinterface

`default_nettype wire

>>> hdl/slfd_cfg.sv
// APB-style register port holding the length limit.
// Depends on slfd_pkg.
`default_nettype none

module slfd_cfg (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready,
  output logic [15:0]      length_limit
);

  logic reg_write;

  assign pready    = 1'b1;
  assign reg_write = psel && penable && pwrite && (paddr[2] == slfd_pkg::REG_LENGTH_LIMIT);

  always_ff @(posedge clk) begin
    if (rst) begin
      length_limit <= slfd_pkg::LENGTH_LIMIT_RESET;
    end else if (reg_write) begin
      length_limit <= pwdata[15:0];
    end
  end

  always_comb begin
    prdata = 32'd0;
    if (paddr[2] == slfd_pkg::REG_LENGTH_LIMIT) begin
      prdata = {16'd0, length_limit};
    end
  end

endmodule

`default_nettype wire

>>> hdl/slfd_parser.sv
// Frame parser: sync hunt, length check, payload indexing and command
// classification, one byte per accepted request. Depends on slfd_pkg.
`default_nettype none

module slfd_parser (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              take,
  input  wire logic [7:0]        rx_byte,
  input  wire logic [15:0]       length_limit,
  output logic                   res_valid,
  output slfd_pkg::result_t      res
);

  localparam logic [1:0] PH_HUNT    = 2'd0;
  localparam logic [1:0] PH_SYNC2   = 2'd1;
  localparam logic [1:0] PH_LENGTH  = 2'd2;
  localparam logic [1:0] PH_PAYLOAD = 2'd3;

  logic [1:0] phase, phase_next;
  logic [7:0] expected_length, expected_length_next;
  logic [7:0] received_count, received_count_next;
  logic [7:0] head [3];
  logic [7:0] head_next [3];
  logic       listen_mode, listen_mode_next;
  logic       timed, timed_next;
  logic [5:0] channel, channel_next;

  logic [15:0] threshold;
  logic        in_payload;
  logic        cmd_pair;
  logic [2:0]  close_kind;

  assign threshold  = (length_limit >= 16'd2) ? (length_limit - 16'd2) : 16'd0;
  assign in_payload = received_count < expected_length;
  assign cmd_pair   = (head[0] == slfd_pkg::CMD_HIGH) && (head[1] == slfd_pkg::CMD_LOW);

  always_comb begin
    phase_next           = phase;
    expected_length_next = expected_length;
    received_count_next  = received_count;
    head_next            = head;
    listen_mode_next     = listen_mode;
    timed_next           = timed;
    channel_next         = channel;
    res_valid            = 1'b0;
    close_kind           = slfd_pkg::KIND_FORWARD;
    res                  = '0;

    unique case (phase)
      PH_HUNT: begin
        if (rx_byte == slfd_pkg::SYNC_FIRST) begin
          phase_next = PH_SYNC2;
        end
      end
      PH_SYNC2: begin
        phase_next = (rx_byte == slfd_pkg::SYNC_SECOND) ? PH_LENGTH : PH_HUNT;
      end
      PH_LENGTH: begin
        if ({8'd0, rx_byte} >= threshold) begin
          expected_length_next = 8'd0;
          phase_next           = PH_HUNT;
        end else begin
          expected_length_next = rx_byte;
          received_count_next  = 8'd0;
          head_next[0]         = 8'd0;
          head_next[1]         = 8'd0;
          head_next[2]         = 8'd0;
          phase_next           = PH_PAYLOAD;
        end
      end
      PH_PAYLOAD: begin
        res_valid = 1'b1;
        if (in_payload) begin
          // Only the first three payload bytes are kept for classification.
          if (received_count < 8'd3) begin
            head_next[received_count[1:0]] = rx_byte;
          end
          received_count_next = received_count + 8'd1;
          res.kind            = slfd_pkg::KIND_PAYLOAD;
          res.data_byte       = rx_byte;
          res.byte_index      = received_count;
        end else begin
          // Closing byte: classify on the kept head bytes.
          if (cmd_pair) begin
            if (head[2] == slfd_pkg::CMD_LISTEN) begin
              close_kind       = slfd_pkg::KIND_BLE_LISTEN;
              listen_mode_next = 1'b1;
              timed_next       = 1'b0;
              channel_next     = slfd_pkg::BLE_CH_FIRST;
            end else if (head[2] >= slfd_pkg::CMD_TIMED_LO &&
                         head[2] <= slfd_pkg::CMD_TIMED_HI) begin
              close_kind       = slfd_pkg::KIND_BLE_TIMED;
              listen_mode_next = 1'b1;
              timed_next       = 1'b1;
              channel_next     = slfd_pkg::BLE_CH_FIRST
                                 + 6'(head[2] - slfd_pkg::CMD_TIMED_LO);
            end
          end else if (head[0] == slfd_pkg::CMD_LOW && head[1] == slfd_pkg::CMD_HIGH &&
                       head[2] == slfd_pkg::CMD_LISTEN) begin
            close_kind       = slfd_pkg::KIND_FAST_MODE;
            listen_mode_next = 1'b0;
            channel_next     = 6'd0;
          end
          phase_next       = PH_HUNT;
          res.kind         = close_kind;
          res.reply_length = (close_kind == slfd_pkg::KIND_FORWARD) ? 9'd0
                             : ({1'b0, expected_length} + 9'd2);
        end
      end
      default: begin
        phase_next = PH_HUNT;
      end
    endcase

    // Every result reports the mode flags as they stand after this byte.
    res.frame_length = expected_length;
    res.ble_listen   = listen_mode_next;
    res.timestamped  = timed_next;
    res.ble_channel  = channel_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= PH_HUNT;
      expected_length <= 8'd0;
      received_count  <= 8'd0;
      head[0]         <= 8'd0;
      head[1]         <= 8'd0;
      head[2]         <= 8'd0;
      listen_mode     <= 1'b0;
      timed           <= 1'b0;
      channel         <= 6'd0;
    end else if (take) begin
      phase           <= phase_next;
      expected_length <= expected_length_next;
      received_count  <= received_count_next;
      head            <= head_next;
      listen_mode     <= listen_mode_next;
      timed           <= timed_next;
      channel         <= channel_next;
    end
  end

endmodule

`default_nettype wire

>>> hdl/slfd_out_stage.sv
// Output register of the deframer: holds one result until the sink takes it.
// Depends on slfd_pkg and slfd_res_if.
`default_nettype none

module slfd_out_stage (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              load,
  input  wire slfd_pkg::result_t load_res,
  output logic                   free,
  slfd_res_if.source             result
);

  logic              full;
  slfd_pkg::result_t held;

  // The stage can take a new result when empty or when its content leaves now.
  assign free = !full || result.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      full <= 1'b0;
    end else if (load) begin
      full <= 1'b1;
    end else if (result.ready) begin
      full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      held <= load_res;
    end
  end

  assign result.valid        = full;
  assign result.kind         = held.kind;
  assign result.data_byte    = held.data_byte;
  assign result.byte_index   = held.byte_index;
  assign result.frame_length = held.frame_length;
  assign result.reply_length = held.reply_length;
  assign result.ble_listen   = held.ble_listen;
  assign result.timestamped  = held.timestamped;
  assign result.ble_channel  = held.ble_channel;

endmodule

`default_nettype wire

>>> hdl/sync_length_frame_deframer_cmd.sv
// Top level of the sync/length frame deframer with command decode.
// Depends on slfd_pkg, slfd_rx_if, slfd_res_if, slfd_cfg, slfd_parser,
// slfd_out_stage and assert_macros.svh.
//
//   Channel   Kind          Carries                               Rate
//   rx        request in    rx_byte, one serial byte              1 per cycle while ready
//   result    request out   kind, byte, index, lengths, mode      0 or 1 per byte
//   apb       register      length_limit at byte address 0        setup + access
//
// Each byte is handled at the edge that accepts it: the parser state is
// updated there, and any result lands in the output register at that edge,
// so it is visible in the cycle after acceptance. The output register is the only
// stall point: rx.ready is low only while it holds a result that is not taken.
// Reset is synchronous (rst, active high) and returns the parser to sync
// hunting with zeroed mode flags and the limit at 256; no clearing pass.
`default_nettype none
`include "assert_macros.svh"

module sync_length_frame_deframer_cmd (
  input  wire logic        clk,
  input  wire logic        rst,
  slfd_rx_if.sink          rx,
  slfd_res_if.source       result,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  logic              stage_free;
  logic              accept;
  logic              res_valid;
  logic              push;
  logic [15:0]       length_limit;
  slfd_pkg::result_t res;

  // A byte is accepted whenever the output register can absorb a possible
  // result in the same edge; bytes that yield nothing are taken alike.
  assign rx.ready = stage_free;
  assign accept   = rx.valid && rx.ready;
  assign push     = accept && res_valid;

  slfd_cfg u_cfg (
    .clk          (clk),
    .rst          (rst),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .length_limit (length_limit)
  );

  // Parser: sync hunt, length screening, payload indexing and the
  // classification of the closing byte; its result is combinational.
  slfd_parser u_parser (
    .clk          (clk),
    .rst          (rst),
    .take         (accept),
    .rx_byte      (rx.rx_byte),
    .length_limit (length_limit),
    .res_valid    (res_valid),
    .res          (res)
  );

  // Output register that decouples the result sink from the byte source.
  slfd_out_stage u_out (
    .clk      (clk),
    .rst      (rst),
    .load     (push),
    .load_res (res),
    .free     (stage_free),
    .result   (result)
  );

  // An accepted byte never finds the output register full and stalled.
  `ASSERT_IMPLIES(a_no_overrun, clk, rst, accept, (!result.valid || result.ready))
  // A pushed result shows up on the port in the next cycle with its kind.
  `ASSERT_NEXT(a_push_visible, clk, rst, push, (result.valid && result.kind == $past(res.kind)))
  // Command results carry a reply length of the frame length plus two.
  `ASSERT_IMPLIES(a_reply_len, clk, rst,
    (result.valid && result.kind != slfd_pkg::KIND_PAYLOAD &&
     result.kind != slfd_pkg::KIND_FORWARD),
    (result.reply_length == 9'(result.frame_length) + 9'd2))

endmodule

`default_nettype wire

>>> tb/slfd_tb_pkg.sv
// Scoreboard class for the sync/length frame deframer testbench: a cycle-free
// copy of the parser that predicts results, plus the queue that checks them.
// Depends on slfd_pkg for the result type, kind codes and frame constants.

package slfd_tb_pkg;

  typedef enum logic [1:0] {
    HUNT_FIRST,
    HUNT_SECOND,
    GET_LENGTH,
    IN_PAYLOAD
  } parse_phase_e;

  class deframe_tracker;
    logic [15:0]       length_limit;
    parse_phase_e      phase;
    logic [7:0]        frame_len;
    logic [7:0]        rx_count;
    logic [7:0]        head [3];
    logic              listen_mode;
    logic              timed;
    logic [5:0]        channel;
    slfd_pkg::result_t pending [$];
    int unsigned       errors;

    function new();
      length_limit = slfd_pkg::LENGTH_LIMIT_RESET;
      phase        = HUNT_FIRST;
      frame_len    = '0;
      rx_count     = '0;
      head         = '{default: 8'h00};
      listen_mode  = 1'b0;
      timed        = 1'b0;
      channel      = '0;
      errors       = 0;
    endfunction

    function slfd_pkg::result_t make_result(logic [2:0] kind, logic [7:0] data,
                                            logic [7:0] idx, logic [8:0] reply);
      slfd_pkg::result_t r;
      r.kind         = kind;
      r.data_byte    = data;
      r.byte_index   = idx;
      r.frame_length = frame_len;
      r.reply_length = reply;
      r.ble_listen   = listen_mode;
      r.timestamped  = timed;
      r.ble_channel  = channel;
      return r;
    endfunction

    // Advances the parser by one accepted byte and queues any result it causes.
    function void note_rx_byte(logic [7:0] b);
      logic [15:0] threshold;
      logic [2:0]  kind;
      case (phase)
        HUNT_FIRST: begin
          if (b == slfd_pkg::SYNC_FIRST) phase = HUNT_SECOND;
        end
        HUNT_SECOND: begin
          phase = (b == slfd_pkg::SYNC_SECOND) ? GET_LENGTH : HUNT_FIRST;
        end
        GET_LENGTH: begin
          threshold = (length_limit >= 16'd2) ? length_limit - 16'd2 : 16'd0;
          if ({8'h00, b} >= threshold) begin
            frame_len = '0;
            phase     = HUNT_FIRST;
          end else begin
            frame_len = b;
            rx_count  = '0;
            head      = '{default: 8'h00};
            phase     = IN_PAYLOAD;
          end
        end
        default: begin
          if (rx_count < frame_len) begin
            if (rx_count < 8'd3) head[rx_count] = b;
            pending.push_back(make_result(slfd_pkg::KIND_PAYLOAD, b, rx_count, 9'd0));
            rx_count = rx_count + 8'd1;
          end else begin
            kind = slfd_pkg::KIND_FORWARD;
            if (head[0] == slfd_pkg::CMD_HIGH && head[1] == slfd_pkg::CMD_LOW) begin
              if (head[2] == slfd_pkg::CMD_LISTEN) begin
                kind        = slfd_pkg::KIND_BLE_LISTEN;
                listen_mode = 1'b1;
                timed       = 1'b0;
                channel     = slfd_pkg::BLE_CH_FIRST;
              end else if (head[2] >= slfd_pkg::CMD_TIMED_LO &&
                           head[2] <= slfd_pkg::CMD_TIMED_HI) begin
                kind        = slfd_pkg::KIND_BLE_TIMED;
                listen_mode = 1'b1;
                timed       = 1'b1;
                channel     = slfd_pkg::BLE_CH_FIRST
                              + 6'(head[2] - slfd_pkg::CMD_TIMED_LO);
              end
            end else if (head[0] == slfd_pkg::CMD_LOW && head[1] == slfd_pkg::CMD_HIGH &&
                         head[2] == slfd_pkg::CMD_LISTEN) begin
              kind        = slfd_pkg::KIND_FAST_MODE;
              listen_mode = 1'b0;
              channel     = '0;
            end
            phase = HUNT_FIRST;
            pending.push_back(make_result(kind, 8'h00, 8'h00,
                                          (kind == slfd_pkg::KIND_FORWARD) ? 9'd0
                                          : {1'b0, frame_len} + 9'd2));
          end
        end
      endcase
    endfunction

    function void compare_field(string name, logic [31:0] expv, logic [31:0] actv);
      if (actv !== expv) begin
        $error("%s: expected %0d, got %0d", name, expv, actv);
        errors++;
      end
    endfunction

    function void check_result(slfd_pkg::result_t got);
      slfd_pkg::result_t want;
      if (pending.size() == 0) begin
        $error("result arrived with no expectation pending");
        errors++;
        return;
      end
      want = pending.pop_front();
      compare_field("kind", 32'(want.kind), 32'(got.kind));
      compare_field("data_byte", 32'(want.data_byte), 32'(got.data_byte));
      compare_field("byte_index", 32'(want.byte_index), 32'(got.byte_index));
      compare_field("frame_length", 32'(want.frame_length), 32'(got.frame_length));
      compare_field("reply_length", 32'(want.reply_length), 32'(got.reply_length));
      compare_field("ble_listen", 32'(want.ble_listen), 32'(got.ble_listen));
      compare_field("timestamped", 32'(want.timestamped), 32'(got.timestamped));
      compare_field("ble_channel", 32'(want.ble_channel), 32'(got.ble_channel));
    endfunction
  endclass

endpackage

>>> tb/tb_top.sv
// Top of the sync/length frame deframer testbench: clock, reset, byte sender,
// result sink with its own stall pattern, APB register writes and readback.
// Depends on slfd_pkg, slfd_rx_if, slfd_res_if, slfd_tb_pkg and the RTL.

module tb_top;

  // The run stays far below this cycle limit.
  localparam int unsigned CYCLE_LIMIT   = 400000;
  // A result shows up in the cycle after its byte; the settle wait lets any
  // trailing work settle before a register write or the end of the run.
  localparam int unsigned SETTLE_CYCLES = 4;
  localparam int unsigned PHASE_ITEMS   = 145;
  localparam int unsigned NUM_PHASES    = 8;
  localparam logic [2:0]  ADDR_LENGTH_LIMIT = 3'(4 * slfd_pkg::REG_LENGTH_LIMIT);

  typedef enum int {
    SINK_ALWAYS,
    SINK_COIN,
    SINK_SLOW,
    SINK_PERIODIC
  } sink_style_e;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        rx_valid = 1'b0;
  logic [7:0]  rx_data = 8'h00;
  logic        sink_ready = 1'b0;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = 3'd0;
  logic [31:0] pwdata = 32'd0;
  logic [31:0] prdata;
  logic        pready;

  slfd_rx_if  rx_ch ();
  slfd_res_if res_ch ();

  assign rx_ch.valid   = rx_valid;
  assign rx_ch.rx_byte = rx_data;
  assign res_ch.ready  = sink_ready;

  sync_length_frame_deframer_cmd u_top (
    .clk     (clk),
    .rst     (rst),
    .rx      (rx_ch),
    .result  (res_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always #1 clk = ~clk;

  slfd_tb_pkg::deframe_tracker tracker;
  slfd_pkg::result_t           seen_result;
  int unsigned                 cycle_count = 0;
  logic [7:0]                  stim_bytes [$];
  int unsigned                 burst_left = 0;
  int unsigned                 phase_sent;
  logic [15:0]                 cur_limit = slfd_pkg::LENGTH_LIMIT_RESET;

  // Monitor. Every handshake is sampled at the rising edge, before any
  // nonblocking update of that edge lands, so the values seen are the ones
  // the block saw. A result is checked before the byte accepted at the same
  // edge is noted: that byte's result cannot appear before the next cycle.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("[sync_length_frame_deframer_cmd] ERROR");
      $finish;
    end
    if (!rst) begin
      if (res_ch.valid && res_ch.ready) begin
        seen_result.kind         = res_ch.kind;
        seen_result.data_byte    = res_ch.data_byte;
        seen_result.byte_index   = res_ch.byte_index;
        seen_result.frame_length = res_ch.frame_length;
        seen_result.reply_length = res_ch.reply_length;
        seen_result.ble_listen   = res_ch.ble_listen;
        seen_result.timestamped  = res_ch.timestamped;
        seen_result.ble_channel  = res_ch.ble_channel;
        tracker.check_result(seen_result);
      end
      if (rx_ch.valid && rx_ch.ready) tracker.note_rx_byte(rx_ch.rx_byte);
      // The register takes its new value at the access edge of a write.
      if (psel && penable && pwrite && pready && paddr == ADDR_LENGTH_LIMIT) begin
        tracker.length_limit = pwdata[15:0];
      end
    end
  end

  // Result sink. It switches between stall styles at random intervals: always
  // ready, a coin toss per cycle, mostly stalled, and a fixed duty pattern.
  sink_style_e sink_style = SINK_ALWAYS;
  int unsigned style_left = 0;

  always @(posedge clk) begin
    if (style_left == 0) begin
      sink_style = sink_style_e'($urandom_range(0, 3));
      style_left = $urandom_range(20, 150);
    end else begin
      style_left--;
    end
    case (sink_style)
      SINK_ALWAYS:   sink_ready <= 1'b1;
      SINK_COIN:     sink_ready <= 1'($urandom_range(0, 1));
      SINK_SLOW:     sink_ready <= ($urandom_range(0, 3) == 0);
      default:       sink_ready <= ((cycle_count % 7) < 4);
    endcase
  end

  // Sends one byte. Bytes go out in bursts; between bursts the valid line
  // drops for a random gap, and now and then a long burst runs with no gap.
  task automatic send_byte(input logic [7:0] b);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 5);
      if (gap != 0) begin
        rx_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(50, 150)
                                               : $urandom_range(1, 24);
    end
    rx_valid <= 1'b1;
    rx_data  <= b;
    @(posedge clk);
    while (!rx_ch.ready) @(posedge clk);
    burst_left--;
  endtask

  task automatic play_bytes();
    while (stim_bytes.size() != 0) begin
      send_byte(stim_bytes.pop_front());
      phase_sent++;
    end
  endtask

  // Waits until every predicted result has been taken, then lets the block
  // settle. The first falling edge makes sure the monitor
  // has already noted the byte accepted at the last rising edge.
  task automatic wait_idle();
    rx_valid <= 1'b0;
    @(negedge clk);
    while (tracker.pending.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Writes the length limit (setup, then access) and reads it straight back
  // in a back-to-back transfer. Called at a rising edge with the block idle.
  task automatic write_length_limit(input logic [15:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ADDR_LENGTH_LIMIT;
    pwdata  <= {16'h0000, value};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    tracker.compare_field("length_limit readback", {16'h0000, value}, prdata);
    psel    <= 1'b0;
    penable <= 1'b0;
    cur_limit = value;
  endtask

  // Queues one random stretch of traffic. Most of it is well-formed frames,
  // many of them commands, so that the classifier sees every branch; the rest
  // is broken sync pairs, over-limit lengths and loose noise.
  task automatic queue_frame();
    int unsigned pick;
    int unsigned len;
    int unsigned thr;
    int unsigned cmd;
    logic [7:0]  hdr [3];
    pick = $urandom_range(0, 99);
    thr  = (cur_limit >= 16'd2) ? cur_limit - 16'd2 : 0;
    if (pick < 75) begin
      cmd = $urandom_range(0, 6);
      hdr[0] = 8'($urandom);
      hdr[1] = 8'($urandom);
      hdr[2] = 8'($urandom);
      case (cmd)
        0: begin
          hdr[0] = slfd_pkg::CMD_HIGH;
          hdr[1] = slfd_pkg::CMD_LOW;
          hdr[2] = slfd_pkg::CMD_LISTEN;
        end
        1: begin
          hdr[0] = slfd_pkg::CMD_HIGH;
          hdr[1] = slfd_pkg::CMD_LOW;
          hdr[2] = slfd_pkg::CMD_TIMED_LO + 8'($urandom_range(0, 2));
        end
        2: begin
          hdr[0] = slfd_pkg::CMD_LOW;
          hdr[1] = slfd_pkg::CMD_HIGH;
          hdr[2] = slfd_pkg::CMD_LISTEN;
        end
        3: begin
          // Near misses around the command bytes.
          hdr[0] = slfd_pkg::CMD_HIGH;
          hdr[1] = slfd_pkg::CMD_LOW;
          hdr[2] = ($urandom_range(0, 1) == 0) ? slfd_pkg::CMD_LISTEN - 8'd1
                                               : slfd_pkg::CMD_TIMED_HI + 8'd1;
        end
        4: begin
          hdr[0] = slfd_pkg::CMD_LOW;
          hdr[1] = slfd_pkg::CMD_HIGH;
          hdr[2] = slfd_pkg::CMD_TIMED_LO + 8'($urandom_range(0, 2));
        end
        default: begin
        end
      endcase
      if ($urandom_range(0, 79) == 0) begin
        len = ($urandom_range(0, 3) == 0) ? 255 : $urandom_range(100, 254);
      end else if (cmd <= 4 && $urandom_range(0, 4) != 0) begin
        len = $urandom_range(3, 6);
      end else begin
        len = $urandom_range(0, 8);
      end
      if (thr != 0 && len >= thr) len = len % thr;
      stim_bytes.push_back(slfd_pkg::SYNC_FIRST);
      stim_bytes.push_back(slfd_pkg::SYNC_SECOND);
      stim_bytes.push_back(8'(len));
      for (int unsigned i = 0; i < len; i++) begin
        stim_bytes.push_back((i < 3) ? hdr[i] : 8'($urandom));
      end
      stim_bytes.push_back(8'($urandom));
    end else if (pick < 85) begin
      // Second sync byte wrong; a repeated first sync byte is included.
      stim_bytes.push_back(slfd_pkg::SYNC_FIRST);
      stim_bytes.push_back(($urandom_range(0, 2) == 0)
                           ? slfd_pkg::SYNC_FIRST
                           : slfd_pkg::SYNC_SECOND ^ 8'($urandom_range(1, 255)));
    end else if (pick < 92) begin
      // Length at or just below the drop threshold, or simply large.
      stim_bytes.push_back(slfd_pkg::SYNC_FIRST);
      stim_bytes.push_back(slfd_pkg::SYNC_SECOND);
      if (thr <= 255 && $urandom_range(0, 1) == 0) begin
        len = (thr > 0 && $urandom_range(0, 1) == 0) ? thr - 1 : thr;
      end else begin
        len = $urandom_range(200, 255);
      end
      stim_bytes.push_back(8'(len));
      // The length may still be accepted, so the frame is closed properly.
      if (len < thr) begin
        for (int unsigned i = 0; i <= len; i++) stim_bytes.push_back(8'($urandom));
      end
    end else begin
      repeat ($urandom_range(1, 6)) begin
        stim_bytes.push_back(($urandom_range(0, 7) == 0) ? slfd_pkg::SYNC_FIRST
                                                         : 8'($urandom));
      end
    end
  endtask

  logic [15:0] limit_plan [NUM_PHASES];

  initial begin
    tracker = new();
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part, at the reset limit. A repeated first sync byte is not
    // taken again as the start of a frame; a length of 255 drops the frame;
    // an empty frame closes on the byte right after its length; then one
    // frame each of the listen, fast-mode and timed commands.
    stim_bytes = '{slfd_pkg::SYNC_FIRST, slfd_pkg::SYNC_FIRST,
                   slfd_pkg::SYNC_FIRST, slfd_pkg::SYNC_SECOND, 8'd255,
                   slfd_pkg::SYNC_FIRST, slfd_pkg::SYNC_SECOND, 8'd0, 8'd255,
                   slfd_pkg::SYNC_FIRST, slfd_pkg::SYNC_SECOND, 8'd3,
                   slfd_pkg::CMD_HIGH, slfd_pkg::CMD_LOW, slfd_pkg::CMD_LISTEN, 8'd0,
                   slfd_pkg::SYNC_FIRST, slfd_pkg::SYNC_SECOND, 8'd3,
                   slfd_pkg::CMD_LOW, slfd_pkg::CMD_HIGH, slfd_pkg::CMD_LISTEN, 8'd255,
                   slfd_pkg::SYNC_FIRST, slfd_pkg::SYNC_SECOND, 8'd3,
                   slfd_pkg::CMD_HIGH, slfd_pkg::CMD_LOW, slfd_pkg::CMD_TIMED_HI, 8'd128};
    play_bytes();

    // Random part, one limit per phase. The smallest limits drop every frame
    // or all but empty ones; the largest lets a length of 255 through.
    limit_plan = '{16'd3, 16'd65535, 16'd20, 16'd2, 16'd257,
                   16'($urandom_range(3, 300)), 16'd0, slfd_pkg::LENGTH_LIMIT_RESET};
    for (int p = 0; p < NUM_PHASES; p++) begin
      wait_idle();
      write_length_limit(limit_plan[p]);
      phase_sent = 0;
      while (phase_sent < PHASE_ITEMS) begin
        queue_frame();
        play_bytes();
      end
    end

    wait_idle();
    if (tracker.errors == 0 && tracker.pending.size() == 0) begin
      $display("[sync_length_frame_deframer_cmd] OK");
    end else begin
      $display("[sync_length_frame_deframer_cmd] ERROR");
    end
    $finish;
  end

endmodule
